/* src/adc_channel_scan_sequencer_assert.svh */
// assertion macros shared by the scan sequencer modules
`ifndef ADC_CHANNEL_SCAN_SEQUENCER_ASSERT_SVH
`define ADC_CHANNEL_SCAN_SEQUENCER_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define ACSS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("scan sequencer check failed");

// consequence that must hold in the cycle after the antecedent
`define ACSS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scan sequencer sequence check failed");

`endif

/* src/acss_pkg.sv */
// shared constants and controller/datapath interface types of the scan sequencer
`default_nettype none

package acss_pkg;

   localparam int CHANNELS    = 8;
   localparam int IDX_BITS    = $clog2(CHANNELS);
   localparam int CHAN_BITS   = 3;
   localparam int SAMPLE_BITS = 10;
   localparam int OP_BITS     = 2;
   localparam int COUNT_BITS  = $clog2(CHANNELS + 1);

   localparam logic [OP_BITS-1:0] OP_ENABLE  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_DISABLE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_DONE    = 2'd2;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic execute;
      logic scan_step;
      logic load;
   } acss_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic need_scan;
      logic hit;
      logic out_free;
   } acss_sts_type;

endpackage

`default_nettype wire

/* src/acss_ctrl.sv */
// controller state machine of the scan sequencer
`default_nettype none

module acss_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  acss_pkg::acss_sts_type sts,
   output acss_pkg::acss_cmd_type cmd
);
   import acss_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXEC   = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = sts.need_scan ? ST_SCAN : ST_FINISH;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.hit) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`include "adc_channel_scan_sequencer_assert.svh"

   `ACSS_ASSERT(a_cmd_onehot, $onehot0({cmd.capture, cmd.execute, cmd.scan_step, cmd.load}))
   `ACSS_ASSERT_NEXT(a_capture_exec, cmd.capture, state_ff == ST_EXEC)
   `ACSS_ASSERT_NEXT(a_finish_hold, (state_ff == ST_FINISH) && !sts.out_free, state_ff == ST_FINISH)

endmodule

`default_nettype wire

/* src/acss_datapath.sv */
// channel table, counters, channel search and result registers of the scan sequencer
`default_nettype none

module acss_datapath (
   input  wire                                 clock,
   input  wire                                 reset,
   input  acss_pkg::acss_cmd_type              cmd,
   output acss_pkg::acss_sts_type              sts,
   input  wire [acss_pkg::OP_BITS-1:0]         req_operation,
   input  wire [acss_pkg::CHAN_BITS-1:0]       req_channel,
   input  wire [acss_pkg::SAMPLE_BITS-1:0]     req_sample,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic                                rsp_report_valid,
   output logic [acss_pkg::CHAN_BITS-1:0]      rsp_report_channel,
   output logic [acss_pkg::SAMPLE_BITS-1:0]    rsp_report_value,
   output logic                                rsp_converter_on,
   output logic                                rsp_start_conversion,
   output logic [acss_pkg::CHAN_BITS-1:0]      rsp_convert_channel,
   output logic [acss_pkg::COUNT_BITS-1:0]     rsp_enabled_total
);
   import acss_pkg::*;

   // channel state
   logic [CHANNELS-1:0]    on_ff, on_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [IDX_BITS-1:0]    active_ff, active_in;
   logic                   power_ff, power_in;
   logic [IDX_BITS-1:0]    scan_ff, scan_in;

   // captured item
   logic [OP_BITS-1:0]     op_ff;
   logic [CHAN_BITS-1:0]   ch_ff;
   logic [SAMPLE_BITS-1:0] smp_ff;

   // result under construction
   logic                   prep_ff, prep_in;
   logic [CHAN_BITS-1:0]   pch_ff, pch_in;
   logic [SAMPLE_BITS-1:0] pval_ff, pval_in;
   logic                   pstart_ff, pstart_in;
   logic [IDX_BITS-1:0]    pconv_ff, pconv_in;

   // output register
   logic                   ovalid_ff, ovalid_in;
   logic                   orep_ff;
   logic [CHAN_BITS-1:0]   och_ff;
   logic [SAMPLE_BITS-1:0] oval_ff;
   logic                   opower_ff;
   logic                   ostart_ff;
   logic [CHAN_BITS-1:0]   oconv_ff;
   logic [COUNT_BITS-1:0]  ocount_ff;

   logic [IDX_BITS-1:0]    ch_idx;
   logic                   ch_ok;
   logic [COUNT_BITS-1:0]  dis_count;

   assign ch_idx    = ch_ff[IDX_BITS-1:0];
   assign ch_ok     = COUNT_BITS'(ch_ff) < COUNT_BITS'(CHANNELS);
   assign dis_count = on_ff[ch_idx] ? count_ff - 1'b1 : count_ff;

   always_comb begin
      on_in     = on_ff;
      count_in  = count_ff;
      active_in = active_ff;
      power_in  = power_ff;
      scan_in   = scan_ff;
      prep_in   = prep_ff;
      pch_in    = pch_ff;
      pval_in   = pval_ff;
      pstart_in = pstart_ff;
      pconv_in  = pconv_ff;

      sts.need_scan = 1'b0;
      case (op_ff)
         OP_ENABLE: sts.need_scan = ch_ok && (count_ff == '0);
         OP_DONE:   sts.need_scan = (count_ff != '0);
         default:   sts.need_scan = 1'b0;
      endcase
      sts.hit      = on_ff[scan_ff];
      sts.out_free = !ovalid_ff || rsp_ready;

      if (cmd.execute) begin
         prep_in   = 1'b0;
         pch_in    = '0;
         pval_in   = '0;
         pstart_in = sts.need_scan;
         pconv_in  = '0;
         // search starts one past the active channel
         scan_in   = (active_ff == IDX_BITS'(CHANNELS - 1)) ? '0 : active_ff + 1'b1;
         case (op_ff)
            OP_ENABLE: begin
               if (ch_ok) begin
                  if (!on_ff[ch_idx]) begin
                     count_in = count_ff + 1'b1;
                  end
                  on_in[ch_idx] = 1'b1;
                  if (count_ff == '0) begin
                     power_in = 1'b1;
                  end
               end
            end
            OP_DISABLE: begin
               if (ch_ok) begin
                  count_in      = dis_count;
                  on_in[ch_idx] = 1'b0;
                  if (dis_count == '0) begin
                     power_in = 1'b0;
                  end
               end
            end
            OP_DONE: begin
               if ((count_ff != '0) && on_ff[active_ff]) begin
                  prep_in = 1'b1;
                  pch_in  = CHAN_BITS'(active_ff);
                  pval_in = smp_ff;
               end
            end
            default: begin
               prep_in = 1'b0;
            end
         endcase
      end

      if (cmd.scan_step) begin
         if (on_ff[scan_ff]) begin
            active_in = scan_ff;
            pconv_in  = scan_ff;
         end else begin
            scan_in = (scan_ff == IDX_BITS'(CHANNELS - 1)) ? '0 : scan_ff + 1'b1;
         end
      end

      if (cmd.load) begin
         ovalid_in = 1'b1;
      end else if (rsp_ready) begin
         ovalid_in = 1'b0;
      end else begin
         ovalid_in = ovalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff     <= '0;
         count_ff  <= '0;
         active_ff <= '0;
         power_ff  <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         on_ff     <= on_in;
         count_ff  <= count_in;
         active_ff <= active_in;
         power_ff  <= power_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      prep_ff   <= prep_in;
      pch_ff    <= pch_in;
      pval_ff   <= pval_in;
      pstart_ff <= pstart_in;
      pconv_ff  <= pconv_in;
      if (cmd.capture) begin
         op_ff  <= req_operation;
         ch_ff  <= req_channel;
         smp_ff <= req_sample;
      end
      if (cmd.load) begin
         orep_ff   <= prep_ff;
         och_ff    <= pch_ff;
         oval_ff   <= pval_ff;
         opower_ff <= power_ff;
         ostart_ff <= pstart_ff;
         oconv_ff  <= CHAN_BITS'(pconv_ff);
         ocount_ff <= count_ff;
      end
   end

   assign rsp_valid            = ovalid_ff;
   assign rsp_report_valid     = orep_ff;
   assign rsp_report_channel   = och_ff;
   assign rsp_report_value     = oval_ff;
   assign rsp_converter_on     = opower_ff;
   assign rsp_start_conversion = ostart_ff;
   assign rsp_convert_channel  = oconv_ff;
   assign rsp_enabled_total    = ocount_ff;

`include "adc_channel_scan_sequencer_assert.svh"

   `ACSS_ASSERT(a_count_matches, count_ff == COUNT_BITS'($countones(on_ff)))
   `ACSS_ASSERT(a_power_matches, power_ff == (count_ff != '0))
   `ACSS_ASSERT(a_scan_nonempty, !cmd.scan_step || (count_ff != '0))
   `ACSS_ASSERT(a_start_enabled, !(cmd.load && pstart_ff) || on_ff[pconv_ff])

endmodule

`default_nettype wire

/* src/adc_channel_scan_sequencer.sv */
// top level of the round robin converter channel scan sequencer
//
// usage
//   req_ channel: one operation per transfer (enable channel, disable channel,
//   conversion complete with its sample); req_ready is high whenever the
//   sequencer is between operations
//   rsp_ channel: exactly one result transfer per request, in request order,
//   giving the reading report, converter power, any conversion start and the
//   number of enabled channels
// sequencing
//   each request is captured and executed and its result is loaded into the
//   output register; when a conversion is started, a next-channel search that
//   examines 1 to 8 channels runs first; the search unit tests one channel
//   table entry per cycle; the next request is taken in the cycle after the
//   result is loaded
// reset
//   all channels disabled, count zero, active channel zero, converter off,
//   no result pending
// stalls
//   a result waiting in the output register does not block the next request;
//   the following result waits in the sequencer until rsp_ready frees the register
`default_nettype none

module adc_channel_scan_sequencer (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire [acss_pkg::OP_BITS-1:0]         req_operation,
   input  wire [acss_pkg::CHAN_BITS-1:0]       req_channel,
   input  wire [acss_pkg::SAMPLE_BITS-1:0]     req_sample,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic                                rsp_report_valid,
   output logic [acss_pkg::CHAN_BITS-1:0]      rsp_report_channel,
   output logic [acss_pkg::SAMPLE_BITS-1:0]    rsp_report_value,
   output logic                                rsp_converter_on,
   output logic                                rsp_start_conversion,
   output logic [acss_pkg::CHAN_BITS-1:0]      rsp_convert_channel,
   output logic [acss_pkg::COUNT_BITS-1:0]     rsp_enabled_total
);
   import acss_pkg::*;

   // command and status between controller and datapath
   acss_cmd_type cmd;
   acss_sts_type sts;

   // sequencing: capture, execute, channel search, result load
   acss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // channel table, counters, search pointer and output register
   acss_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_operation        (req_operation),
      .req_channel          (req_channel),
      .req_sample           (req_sample),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_report_valid     (rsp_report_valid),
      .rsp_report_channel   (rsp_report_channel),
      .rsp_report_value     (rsp_report_value),
      .rsp_converter_on     (rsp_converter_on),
      .rsp_start_conversion (rsp_start_conversion),
      .rsp_convert_channel  (rsp_convert_channel),
      .rsp_enabled_total    (rsp_enabled_total)
   );

endmodule

`default_nettype wire
